// ===== rtl/obst_pkg.sv =====
// obst_pkg: shared types, codes and constants for the box suppression table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package obst_pkg;
    localparam int MaxBoxes = 16;
    localparam int IdxW     = 4;
    localparam int CntW     = 5;
    localparam int CoordW   = 13;

    typedef enum logic [1:0] {
        t_OP_INSERT = 2'd0,
        t_OP_READ   = 2'd1,
        t_OP_CLEAR  = 2'd2,
        t_OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_REPLACED = 3'd0,
        ACT_DROPPED  = 3'd1,
        ACT_APPENDED = 3'd2,
        ACT_EVICTED  = 3'd3,
        ACT_READ     = 3'd4,
        ACT_CLEARED  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_CALC,
        ST_TEST,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;     // capture input item, reset scan
        logic       show;     // copy the read entry into the result
        logic       fetch;    // register stored entry at scan index
        logic       calc;     // register intersection / areas
        logic       test;     // evaluate overlap and minimum, advance
        logic       finish;   // form result
        logic       out_take; // output transfer
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       scan_done; // scan index reached count
        logic       hit;       // overlap found at current entry
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/online_box_suppression_table.sv =====
// online_box_suppression_table: top level, apb register and handshake wiring
// depends on obst_pkg, obst_ctrl, obst_datapath
`timescale 1ns / 1ps
`default_nettype none
// Greedy overlap suppression over a 16-entry box table. An insert passes
// through accept, then per stored entry scanned a fetch from the table memory,
// one registered multiply stage for the intersection and areas, and the
// cross-multiplied ratio compare, then a final fetch and the result; a read
// goes through accept, table read and result, and a clear through accept and
// result. One item is in work at a time; input stall is high until its result
// transfer completes. Operation code three is taken and gives no result.
// Register 0 at byte address 0 is the overlap threshold in 1/256 units.
module online_box_suppression_table (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [1:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [1:0]         i_operation,
    input  wire  signed [11:0] i_x_center,
    input  wire  signed [11:0] i_y_center,
    input  wire  [10:0]        i_box_width,
    input  wire  [10:0]        i_box_height,
    input  wire  [15:0]        i_score,
    input  wire  [15:0]        i_distance,
    input  wire  [1:0]         i_class_id,
    input  wire  [3:0]         i_read_index,
    output logic               o_valid,
    input  wire                i_stall,
    output logic [2:0]         o_action,
    output logic [3:0]         o_slot,
    output logic [4:0]         o_entry_count,
    output logic               o_entry_valid,
    output logic signed [12:0] o_left_edge,
    output logic signed [12:0] o_top_edge,
    output logic signed [12:0] o_right_edge,
    output logic signed [12:0] o_bottom_edge,
    output logic [15:0]        o_entry_score,
    output logic [15:0]        o_entry_distance,
    output logic [1:0]         o_entry_class
);
    logic [7:0] r_thresh;
    obst_pkg::t_cmd cmd;
    obst_pkg::t_sts sts;

    // apb register: only address zero holds the threshold
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, r_thresh} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thresh <= 8'd115;
        else if (psel && penable && pwrite && paddr == 2'd0) r_thresh <= pwdata[7:0];
    end

    obst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    obst_datapath u_dp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_cmd (cmd), .o_sts (sts),
        .i_thresh (r_thresh), .i_operation (i_operation),
        .i_x_center (i_x_center), .i_y_center (i_y_center),
        .i_box_width (i_box_width), .i_box_height (i_box_height),
        .i_score (i_score), .i_distance (i_distance), .i_class_id (i_class_id),
        .i_read_index (i_read_index),
        .o_action (o_action), .o_slot (o_slot), .o_entry_count (o_entry_count),
        .o_entry_valid (o_entry_valid), .o_left_edge (o_left_edge),
        .o_top_edge (o_top_edge), .o_right_edge (o_right_edge),
        .o_bottom_edge (o_bottom_edge), .o_entry_score (o_entry_score),
        .o_entry_distance (o_entry_distance), .o_entry_class (o_entry_class)
    );

    // stored count never exceeds the table depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= 5'd16)) else $error("count overflow");
    // a clear result always reports an empty table
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == obst_pkg::ACT_CLEARED) |-> (o_entry_count == 5'd0))
        else $error("clear not empty");
    // input side is held while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open with pending result");
endmodule
`default_nettype wire

// ===== rtl/obst_ctrl.sv =====
// obst_ctrl: sequencing state machine for insert, read and clear items
// depends on obst_pkg
`timescale 1ns / 1ps
`default_nettype none
module obst_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire [1:0]       i_operation,
    input  wire             i_out_stall,
    input  obst_pkg::t_sts  i_sts,
    output obst_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);
    obst_pkg::t_state r_state, n_state;
    logic take;

    assign take = i_valid && (r_state == obst_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            obst_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_operation == obst_pkg::t_OP_INSERT) n_state = obst_pkg::ST_FETCH;
                    else if (i_operation == obst_pkg::t_OP_READ) n_state = obst_pkg::ST_READ;
                    else if (i_operation == obst_pkg::t_OP_CLEAR) n_state = obst_pkg::ST_OUT;
                end
            end
            obst_pkg::ST_READ: n_state = obst_pkg::ST_OUT;
            obst_pkg::ST_FETCH: begin
                if (i_sts.scan_done) n_state = obst_pkg::ST_OUT;
                else n_state = obst_pkg::ST_CALC;
            end
            obst_pkg::ST_CALC: n_state = obst_pkg::ST_TEST;
            obst_pkg::ST_TEST: begin
                if (i_sts.hit) n_state = obst_pkg::ST_OUT;
                else n_state = obst_pkg::ST_FETCH;
            end
            obst_pkg::ST_OUT: begin
                if (!i_out_stall) n_state = obst_pkg::ST_IDLE;
            end
            default: n_state = obst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = take;
        o_cmd.show     = (r_state == obst_pkg::ST_READ);
        o_cmd.fetch    = (r_state == obst_pkg::ST_FETCH);
        o_cmd.calc     = (r_state == obst_pkg::ST_CALC);
        o_cmd.test     = (r_state == obst_pkg::ST_TEST);
        o_cmd.finish   = (r_state == obst_pkg::ST_FETCH && i_sts.scan_done)
                      || (r_state == obst_pkg::ST_TEST && i_sts.hit);
        o_cmd.out_take = (r_state == obst_pkg::ST_OUT) && !i_out_stall;
        o_in_stall     = (r_state != obst_pkg::ST_IDLE);
        o_out_valid    = (r_state == obst_pkg::ST_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= obst_pkg::ST_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

// ===== rtl/obst_datapath.sv =====
// obst_datapath: box table memory, overlap arithmetic and result registers
// depends on obst_pkg
`timescale 1ns / 1ps
`default_nettype none
module obst_datapath (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  obst_pkg::t_cmd         i_cmd,
    output obst_pkg::t_sts         o_sts,
    input  wire  [7:0]             i_thresh,
    input  wire  [1:0]             i_operation,
    input  wire  signed [11:0]     i_x_center,
    input  wire  signed [11:0]     i_y_center,
    input  wire  [10:0]            i_box_width,
    input  wire  [10:0]            i_box_height,
    input  wire  [15:0]            i_score,
    input  wire  [15:0]            i_distance,
    input  wire  [1:0]             i_class_id,
    input  wire  [3:0]             i_read_index,
    output logic [2:0]             o_action,
    output logic [3:0]             o_slot,
    output logic [4:0]             o_entry_count,
    output logic                   o_entry_valid,
    output logic signed [12:0]     o_left_edge,
    output logic signed [12:0]     o_top_edge,
    output logic signed [12:0]     o_right_edge,
    output logic signed [12:0]     o_bottom_edge,
    output logic [15:0]            o_entry_score,
    output logic [15:0]            o_entry_distance,
    output logic [1:0]             o_entry_class
);
    localparam int EntW = 4 * obst_pkg::CoordW + 16 + 16 + 2;
    typedef logic [EntW-1:0] t_entry;

    t_entry mem [obst_pkg::MaxBoxes];
    t_entry r_rd;

    logic [obst_pkg::CntW-1:0] r_count;
    logic [obst_pkg::CntW-1:0] r_idx;
    logic [1:0]                r_op;
    logic [3:0]                r_ridx;
    logic signed [12:0]        r_l, r_t, r_r, r_b;
    logic [15:0]               r_sc, r_dist;
    logic [1:0]                r_cls;
    logic [21:0]               r_a1;
    logic [15:0]               r_low_sc;
    logic [3:0]                r_low_idx;
    logic [23:0]               r_inter;
    logic [24:0]               r_a2;

    // entry field views of the fetched word
    logic signed [12:0] e_l, e_t, e_r, e_b;
    logic [15:0]        e_sc, e_d;
    logic [1:0]         e_c;
    assign {e_l, e_t, e_r, e_b, e_sc, e_d, e_c} = r_rd;

    // corners of the incoming box
    logic signed [12:0] c_l, c_t;
    assign c_l = 13'(i_x_center) - 13'({2'b0, i_box_width[10:1]});
    assign c_t = 13'(i_y_center) - 13'({2'b0, i_box_height[10:1]});

    // intersection extents
    logic signed [13:0] iw, ih;
    logic signed [12:0] mr, ml, mb, mt;
    assign mr = (r_r < e_r) ? r_r : e_r;
    assign ml = (r_l > e_l) ? r_l : e_l;
    assign mb = (r_b < e_b) ? r_b : e_b;
    assign mt = (r_t > e_t) ? r_t : e_t;
    assign iw = 14'(mr) - 14'(ml);
    assign ih = 14'(mb) - 14'(mt);
    logic [12:0] iwp, ihp;
    assign iwp = iw[13] ? '0 : iw[12:0];
    assign ihp = ih[13] ? '0 : ih[12:0];
    logic signed [13:0] ew, eh;
    assign ew = 14'(e_r) - 14'(e_l);
    assign eh = 14'(e_b) - 14'(e_t);

    // overlap test: inter*256 > thr*(a1+a2-inter)
    logic signed [26:0] uni;
    logic signed [36:0] lhs, rhs;
    logic               hit;
    assign uni = 27'(r_a1) + 27'(signed'(r_a2)) - 27'(r_inter);
    assign lhs = 37'({r_inter, 8'd0});
    assign rhs = 37'(signed'({1'b0, i_thresh})) * 37'(uni);
    assign hit = i_cmd.test && (lhs > rhs);

    logic [3:0] idx;
    assign idx = r_idx[3:0];

    assign o_sts.scan_done = (r_idx >= r_count);
    assign o_sts.hit       = hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_rd <= mem[i_read_index];
        else if (i_cmd.fetch) r_rd <= mem[idx];
        if (i_cmd.finish && r_op == obst_pkg::t_OP_INSERT) begin
            if (hit) begin
                if (r_sc > e_sc) mem[idx] <= {r_l, r_t, r_r, r_b, r_sc, r_dist, r_cls};
            end else if (r_count >= 5'(obst_pkg::MaxBoxes)) begin
                mem[r_low_idx] <= {r_l, r_t, r_r, r_b, r_sc, r_dist, r_cls};
            end else begin
                mem[r_count[3:0]] <= {r_l, r_t, r_r, r_b, r_sc, r_dist, r_cls};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_ridx <= i_read_index;
            r_l    <= c_l;
            r_t    <= c_t;
            r_r    <= c_l + 13'({2'b0, i_box_width});
            r_b    <= c_t + 13'({2'b0, i_box_height});
            r_sc   <= i_score;
            r_dist <= i_distance;
            r_cls  <= i_class_id;
            r_a1   <= 22'(i_box_width * i_box_height);
        end
        if (i_cmd.calc) begin
            r_inter <= 24'(iwp * ihp);
            r_a2    <= 25'(ew * eh);
        end
        if (i_cmd.test && !hit) begin
            if (idx == '0 || e_sc < r_low_sc) begin
                r_low_sc  <= e_sc;
                r_low_idx <= idx;
            end
        end
    end

    // scan index and stored count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                if (i_operation == obst_pkg::t_OP_CLEAR) r_count <= '0;
            end
            if (i_cmd.test && !hit) r_idx <= r_idx + 1'b1;
            if (i_cmd.finish && !hit && r_count < 5'(obst_pkg::MaxBoxes))
                r_count <= r_count + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_operation != obst_pkg::t_OP_INSERT) begin
            o_entry_valid <= 1'b0;
            {o_left_edge, o_top_edge, o_right_edge, o_bottom_edge} <= '0;
            {o_entry_score, o_entry_distance, o_entry_class} <= '0;
            o_slot <= '0;
            if (i_operation == obst_pkg::t_OP_CLEAR) begin
                o_action      <= obst_pkg::ACT_CLEARED;
                o_entry_count <= '0;
            end else begin
                o_action      <= obst_pkg::ACT_READ;
                o_entry_count <= r_count;
                o_slot        <= i_read_index;
            end
        end else if (i_cmd.show && 5'(r_ridx) < r_count) begin
            o_entry_valid    <= 1'b1;
            o_left_edge      <= e_l;
            o_top_edge       <= e_t;
            o_right_edge     <= e_r;
            o_bottom_edge    <= e_b;
            o_entry_score    <= e_sc;
            o_entry_distance <= e_d;
            o_entry_class    <= e_c;
        end else if (i_cmd.finish) begin
            o_entry_valid <= 1'b0;
            {o_left_edge, o_top_edge, o_right_edge, o_bottom_edge} <= '0;
            {o_entry_score, o_entry_distance, o_entry_class} <= '0;
            if (hit) begin
                o_slot        <= idx;
                o_action      <= (r_sc > e_sc) ? obst_pkg::ACT_REPLACED
                                               : obst_pkg::ACT_DROPPED;
                o_entry_count <= r_count;
            end else if (r_count >= 5'(obst_pkg::MaxBoxes)) begin
                o_slot        <= r_low_idx;
                o_action      <= obst_pkg::ACT_EVICTED;
                o_entry_count <= r_count;
            end else begin
                o_slot        <= r_count[3:0];
                o_action      <= obst_pkg::ACT_APPENDED;
                o_entry_count <= r_count + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb_online_box_suppression_table.sv =====
// tb_online_box_suppression_table: self-checking bench for the box suppression table
// depends on obst_pkg and online_box_suppression_table
`timescale 1ns / 1ps
`default_nettype none
module tb_online_box_suppression_table;
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [11:0] xc;
        logic signed [11:0] yc;
        logic [10:0]        w;
        logic [10:0]        h;
        logic [15:0]        sc;
        logic [15:0]        distance;
        logic [1:0]         cls;
        logic [3:0]         ridx;
    } t_box_item;

    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         slot;
        logic [4:0]         count;
        logic               valid;
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic signed [12:0] right;
        logic signed [12:0] bottom;
        logic [15:0]        sc;
        logic [15:0]        distance;
        logic [1:0]         cls;
    } t_box_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    t_box_item cur = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    t_box_result got;

    online_box_suppression_table DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(cur.op), .i_x_center(cur.xc), .i_y_center(cur.yc),
        .i_box_width(cur.w), .i_box_height(cur.h), .i_score(cur.sc),
        .i_distance(cur.distance), .i_class_id(cur.cls), .i_read_index(cur.ridx),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_action(got.action), .o_slot(got.slot), .o_entry_count(got.count),
        .o_entry_valid(got.valid), .o_left_edge(got.left), .o_top_edge(got.top),
        .o_right_edge(got.right), .o_bottom_edge(got.bottom),
        .o_entry_score(got.sc), .o_entry_distance(got.distance),
        .o_entry_class(got.cls)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the table, kept by the predictor
    logic signed [12:0] tbl_l [obst_pkg::MaxBoxes];
    logic signed [12:0] tbl_t [obst_pkg::MaxBoxes];
    logic signed [12:0] tbl_r [obst_pkg::MaxBoxes];
    logic signed [12:0] tbl_b [obst_pkg::MaxBoxes];
    logic [15:0] tbl_sc [obst_pkg::MaxBoxes];
    logic [15:0] tbl_d [obst_pkg::MaxBoxes];
    logic [1:0]  tbl_c [obst_pkg::MaxBoxes];
    int          tbl_count;
    logic [7:0]  threshold;

    t_box_item   pending_items [$];
    t_box_result expected_results [$];
    int          failures;
    bit          feeding_done;
    int          hold_off = 0;     // long receiver hold-off, in cycles
    int          idle_cycles = 0;  // watchdog

    // greedy suppression step on the shadow table
    function automatic void suppress_step(input t_box_item it);
        t_box_result r;
        logic signed [12:0] l, t, rt, bt;
        longint iw, ih, inter, a1, a2, uni;
        int low_idx, hit;
        logic [15:0] low_sc;
        r = '0;
        if (it.op == obst_pkg::t_OP_NONE) return;
        if (it.op == obst_pkg::t_OP_CLEAR) begin
            tbl_count = 0;
            r.action = obst_pkg::ACT_CLEARED;
        end else if (it.op == obst_pkg::t_OP_READ) begin
            r.action = obst_pkg::ACT_READ;
            r.slot = it.ridx;
            if (int'(it.ridx) < tbl_count) begin
                r.valid = 1'b1;
                r.left = tbl_l[it.ridx]; r.top = tbl_t[it.ridx];
                r.right = tbl_r[it.ridx]; r.bottom = tbl_b[it.ridx];
                r.sc = tbl_sc[it.ridx]; r.distance = tbl_d[it.ridx];
                r.cls = tbl_c[it.ridx];
            end
        end else begin
            l = 13'(int'(it.xc) - int'(it.w) / 2);
            t = 13'(int'(it.yc) - int'(it.h) / 2);
            rt = l + 13'(it.w);
            bt = t + 13'(it.h);
            a1 = longint'(it.w) * longint'(it.h);
            low_idx = 0; low_sc = '0; hit = -1;
            for (int i = 0; i < tbl_count; i++) begin
                iw = (rt < tbl_r[i] ? rt : tbl_r[i]) - (l > tbl_l[i] ? l : tbl_l[i]);
                ih = (bt < tbl_b[i] ? bt : tbl_b[i]) - (t > tbl_t[i] ? t : tbl_t[i]);
                if (iw < 0) iw = 0;
                if (ih < 0) ih = 0;
                inter = iw * ih;
                a2 = longint'(tbl_r[i] - tbl_l[i]) * longint'(tbl_b[i] - tbl_t[i]);
                uni = a1 + a2 - inter;
                if (inter * 256 > longint'(threshold) * uni) begin
                    hit = i;
                    break;
                end
                if (i == 0 || tbl_sc[i] < low_sc) begin
                    low_sc = tbl_sc[i];
                    low_idx = i;
                end
            end
            if (hit >= 0) begin
                r.slot = 4'(hit);
                r.action = (it.sc > tbl_sc[hit]) ? obst_pkg::ACT_REPLACED
                                                 : obst_pkg::ACT_DROPPED;
            end else if (tbl_count >= obst_pkg::MaxBoxes) begin
                hit = low_idx;
                r.action = obst_pkg::ACT_EVICTED;
                r.slot = 4'(low_idx);
            end else begin
                hit = tbl_count;
                r.action = obst_pkg::ACT_APPENDED;
                r.slot = 4'(tbl_count);
                tbl_count++;
            end
            if (r.action != obst_pkg::ACT_DROPPED) begin
                tbl_l[hit] = l; tbl_t[hit] = t; tbl_r[hit] = rt; tbl_b[hit] = bt;
                tbl_sc[hit] = it.sc; tbl_d[hit] = it.distance; tbl_c[hit] = it.cls;
            end
        end
        r.count = 5'(tbl_count);
        expected_results.push_back(r);
    endfunction

    // driver: one gap per item, payload held while stalled
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            suppress_step(cur);
        end
        if (i_valid && o_stall) begin
            // hold payload
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_valid <= 1'b0;
        end else if (pending_items.size() > 0 && i_rst_n) begin
            cur <= pending_items.pop_front();
            i_valid <= 1'b1;
            send_gap <= $urandom_range(0, 6) * ($urandom_range(0, 3) != 0);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // monitor: checks each result transfer against the oldest expectation
    int recv_gap = 0;
    int recv_draw;
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no expectation: action %0d", got.action);
                failures++;
            end else begin
                t_box_result e;
                e = expected_results.pop_front();
                if (got.action !== e.action) begin
                    $error("action exp %0d got %0d", e.action, got.action); failures++; end
                if (got.slot !== e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, got.slot); failures++; end
                if (got.count !== e.count) begin
                    $error("entry_count exp %0d got %0d", e.count, got.count); failures++; end
                if (got.valid !== e.valid) begin
                    $error("entry_valid exp %0d got %0d", e.valid, got.valid); failures++; end
                if (got.left !== e.left) begin
                    $error("left_edge exp %0d got %0d", e.left, got.left); failures++; end
                if (got.top !== e.top) begin
                    $error("top_edge exp %0d got %0d", e.top, got.top); failures++; end
                if (got.right !== e.right) begin
                    $error("right_edge exp %0d got %0d", e.right, got.right); failures++; end
                if (got.bottom !== e.bottom) begin
                    $error("bottom_edge exp %0d got %0d", e.bottom, got.bottom); failures++; end
                if (got.sc !== e.sc) begin
                    $error("entry_score exp %0d got %0d", e.sc, got.sc); failures++; end
                if (got.distance !== e.distance) begin
                    $error("entry_distance exp %0d got %0d", e.distance, got.distance);
                    failures++; end
                if (got.cls !== e.cls) begin
                    $error("entry_class exp %0d got %0d", e.cls, got.cls); failures++; end
            end
        end
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            recv_draw = $urandom_range(0, 6) * ($urandom_range(0, 3) != 0);
            i_stall <= (recv_draw != 0);
            recv_gap <= recv_draw;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= (recv_gap > 1);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles without a transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable && pwrite))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("tb_online_box_suppression_table NOT OK");
            $finish;
        end
    end

    task automatic write_threshold(input logic [7:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= REG_THRESHOLD; pwdata <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        threshold = value;
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_box_item rand_box(input int spread);
        t_box_item it;
        it = '0;
        it.op = obst_pkg::t_OP_INSERT;
        it.xc = 12'($urandom_range(0, spread) - 256);
        it.yc = 12'($urandom_range(0, spread) - 256);
        it.w = 11'($urandom_range(0, 2047));
        it.h = 11'($urandom_range(0, 2047));
        if ($urandom_range(0, 1)) begin
            it.w = 11'($urandom_range(0, 300));
            it.h = 11'($urandom_range(0, 300));
        end
        it.sc = 16'($urandom);
        it.distance = 16'($urandom);
        it.cls = 2'($urandom);
        it.ridx = 4'($urandom);
        return it;
    endfunction

    function automatic t_box_item mk(input logic [1:0] op, input int x, input int y,
                                     input int w, input int h, input int sc,
                                     input int ridx);
        t_box_item it;
        it = '0;
        it.op = op; it.xc = 12'(x); it.yc = 12'(y); it.w = 11'(w); it.h = 11'(h);
        it.sc = 16'(sc); it.distance = 16'($urandom); it.cls = 2'($urandom);
        it.ridx = 4'(ridx);
        return it;
    endfunction

    function automatic t_box_item mix_item(input int spread);
        t_box_item it;
        int pick;
        pick = $urandom_range(0, 19);
        it = rand_box(spread);
        if (pick < 3) it.op = obst_pkg::t_OP_READ;
        else if (pick == 3) it.op = obst_pkg::t_OP_CLEAR;
        else if (pick == 4) it.op = obst_pkg::t_OP_NONE;
        return it;
    endfunction

    initial begin
        t_box_item it;
        logic [7:0] thr_set [4];
        failures = 0; tbl_count = 0; threshold = 8'd115;
        thr_set = '{8'd0, 8'd255, 8'd115, 8'd40};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_threshold(8'd115);

        // directed: extremes, each operation, equal score drop, zero union
        pending_items.push_back(mk(obst_pkg::t_OP_READ, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_INSERT, -256, -256, 2047, 2047, 65535, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_INSERT, -256, -256, 2047, 2047, 65535, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_INSERT, -256, -256, 2047, 2047, 0, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_INSERT, 2047, 2047, 0, 0, 100, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_INSERT, 2047, 2047, 0, 0, 200, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_INSERT, 2047, -256, 2047, 1, 5, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_READ, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_READ, 0, 0, 0, 0, 0, 2));
        pending_items.push_back(mk(obst_pkg::t_OP_READ, 0, 0, 0, 0, 0, 15));
        pending_items.push_back(mk(obst_pkg::t_OP_NONE, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 13; i++)
            pending_items.push_back(mk(obst_pkg::t_OP_INSERT, 150 * i - 200, 1800, 60, 60,
                                       (i * 7) % 5, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_INSERT, 0, 0, 4, 4, 3, 0));
        pending_items.push_back(mk(obst_pkg::t_OP_CLEAR, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // random phases over several thresholds; table often fills up
        foreach (thr_set[k]) begin
            write_threshold(thr_set[k]);
            for (int n = 0; n < 300; n++) begin
                it = mix_item((n % 3 == 0) ? 600 : 2303);
                pending_items.push_back(it);
                if (k == 1 && n == 150) begin
                    wait (pending_items.size() < 5);
                    hold_off = 300;
                end
            end
            for (int j = 0; j < 16; j++)
                pending_items.push_back(mk(obst_pkg::t_OP_READ, 0, 0, 0, 0, 0, j));
            wait_drained();
        end

        if (failures == 0) begin
            $display("tb_online_box_suppression_table OK");
        end else begin
            $display("tb_online_box_suppression_table NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/obst_pkg.sv
rtl/obst_ctrl.sv
rtl/obst_datapath.sv
rtl/online_box_suppression_table.sv
verif/tb_online_box_suppression_table.sv
